// ===== rtl/core/fixed_chunk_pool_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed chunk pool allocator
// Clocked, reset-qualified property checks used by the allocator module.
// ----------------------------------------------------------------------------
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_ASSERT_SVH

// Property must hold at every rising edge outside of reset
`define FCPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen outside of reset
`define FCPA_ASSERT_NEVER(label, cond, msg) \
    `FCPA_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/fcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared constants of the fixed chunk pool allocator: operation and status
// codes, field widths and default pool geometry.
// ----------------------------------------------------------------------------
package fcpa_pkg;

    // default pool geometry
    localparam int CPB_DEFAULT = 16;
    localparam int MAX_BLOCKS_DEFAULT = 16;

    // payload field widths
    localparam int SIZE_W = 16;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;
    localparam int FREE_CNT_W = 9;
    localparam int BLK_CNT_W = 5;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 2'd3;

endpackage

// ===== rtl/core/fcpa_ram.sv =====
// ----------------------------------------------------------------------------
// fcpa_ram
// Chunk state memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcpa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 10,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fixed_chunk_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator: result registered when the step after the input transfer
// retires; no new transfer is taken until then. The chunk memory read (list head for
// alloc, handle for free) precedes the read-modify-write; a stalled result holds the next item.
// Reset (i_rst_n low, synchronous): empty list, no blocks, no result pending.
// ----------------------------------------------------------------------------
`include "fixed_chunk_pool_allocator_assert.svh"

module fixed_chunk_pool_allocator #(
    parameter int CHUNKS_PER_BLOCK = fcpa_pkg::CPB_DEFAULT,
    parameter int MAX_BLOCKS = fcpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  logic [fcpa_pkg::SIZE_W-1:0]     i_request_size,
    input  logic [fcpa_pkg::HANDLE_W-1:0]   i_chunk_handle,
    input  logic                            i_null_handle,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fcpa_pkg::STATUS_W-1:0]   o_status,
    output logic [fcpa_pkg::HANDLE_W-1:0]   o_granted_chunk,
    output logic [fcpa_pkg::FREE_CNT_W-1:0] o_free_chunks,
    output logic [fcpa_pkg::BLK_CNT_W-1:0]  o_blocks_in_use
);

    import fcpa_pkg::*;

    localparam int TOTAL = CHUNKS_PER_BLOCK * MAX_BLOCKS;
    localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int IDXP_W = IDX_W + 1;
    localparam int CNT_W = $clog2(TOTAL + 1);
    localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (IDXP_W > HANDLE_W) ? IDXP_W : HANDLE_W;
    // memory word: {taken, end of list, link}
    localparam int WORD_W = IDX_W + 2;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;

    // captured request
    logic                r_op;
    logic                r_size_zero;
    logic                r_null;
    logic [CMP_W-1:0]    r_handle;

    // pool state
    logic                r_head_vld, n_head_vld;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDXP_W-1:0]   r_front, n_front;
    logic [IDXP_W-1:0]   r_open, n_open;
    logic [BLK_W-1:0]    r_blocks, n_blocks;
    logic [CNT_W-1:0]    r_free_total, n_free_total;

    // result register
    logic                r_ovld;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_granted, n_granted;

    // memory ports
    logic                w_re;
    logic [IDX_W-1:0]    w_raddr;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [WORD_W-1:0]   w_wdata;
    logic [WORD_W-1:0]   w_rdata;
    logic                w_rd_taken;
    logic [CMP_W-1:0]    w_in_handle;
    logic [IDX_W-1:0]    w_chunk;
    logic                w_in_fire;
    logic                w_fire;

    assign w_in_handle = CMP_W'(i_chunk_handle);
    assign w_in_fire = i_valid && (r_state == S_IDLE);
    // the step retires once the result register is free
    assign w_fire = (r_state == S_EXEC) && (!r_ovld || i_ready);
    assign w_rd_taken = w_rdata[WORD_W-1];

    // read the entry the step will modify: head for alloc, handle for free
    assign w_re = w_in_fire;
    assign w_raddr = (i_operation == OP_FREE) ? IDX_W'(w_in_handle) : r_head;

    fcpa_ram #(
        .DEPTH  (TOTAL),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // capture the request
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op <= i_operation;
            r_size_zero <= (i_request_size == '0);
            r_null <= i_null_handle;
            r_handle <= w_in_handle;
        end
    end

    // step decision and write-back
    always_comb begin
        n_head_vld = r_head_vld;
        n_head = r_head;
        n_front = r_front;
        n_open = r_open;
        n_blocks = r_blocks;
        n_free_total = r_free_total;
        n_status = ST_OK;
        n_granted = '0;
        w_we = 1'b0;
        w_chunk = r_head;
        w_wdata = {1'b1, 1'b1, r_head};
        if (r_op == OP_ALLOC) begin
            if (r_size_zero) begin
                n_status = ST_NULL;
            end else if (r_head_vld) begin
                // pop the list head
                w_chunk = r_head;
                n_head_vld = !w_rdata[IDX_W];
                n_head = w_rdata[IDX_W-1:0];
                n_free_total = r_free_total - 1'b1;
                w_we = 1'b1;
            end else if (r_front < r_open) begin
                // next never-used chunk of the newest block
                w_chunk = r_front[IDX_W-1:0];
                n_front = r_front + 1'b1;
                n_free_total = r_free_total - 1'b1;
                w_we = 1'b1;
            end else if (r_blocks < BLK_W'(MAX_BLOCKS)) begin
                // open a block, grant its first chunk
                w_chunk = r_open[IDX_W-1:0];
                n_front = r_open + 1'b1;
                n_open = r_open + IDXP_W'(CHUNKS_PER_BLOCK);
                n_blocks = r_blocks + 1'b1;
                n_free_total = r_free_total + CNT_W'(CHUNKS_PER_BLOCK - 1);
                w_we = 1'b1;
            end else begin
                n_status = ST_FULL;
            end
            n_granted = (n_status == ST_OK) ? HANDLE_W'(w_chunk) : '0;
            w_wdata = {1'b1, 1'b1, w_chunk};
        end else begin
            w_chunk = IDX_W'(r_handle);
            if (r_null) begin
                n_status = ST_NULL;
            end else if (!(r_handle < CMP_W'(r_front)) || !w_rd_taken) begin
                // beyond the used range, or already free
                n_status = ST_NOT_TAKEN;
            end else begin
                // push onto the list head
                w_we = 1'b1;
                w_wdata = {1'b0, !r_head_vld, r_head};
                n_head_vld = 1'b1;
                n_head = w_chunk;
                n_free_total = r_free_total + 1'b1;
            end
        end
        w_we = w_we && w_fire;
        w_waddr = w_chunk;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and pool state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld <= 1'b0;
            r_head_vld <= 1'b0;
            r_head <= '0;
            r_front <= '0;
            r_open <= '0;
            r_blocks <= '0;
            r_free_total <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_ovld <= 1'b1;
                r_head_vld <= n_head_vld;
                r_head <= n_head;
                r_front <= n_front;
                r_open <= n_open;
                r_blocks <= n_blocks;
                r_free_total <= n_free_total;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_granted <= n_granted;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovld;
    assign o_status = r_status;
    assign o_granted_chunk = r_granted;
    assign o_free_chunks = FREE_CNT_W'(r_free_total);
    assign o_blocks_in_use = BLK_CNT_W'(r_blocks);

    // checks
    `FCPA_ASSERT(a_stall_holds, (r_state == S_EXEC && r_ovld && !i_ready) |=> (r_state == S_EXEC), "step retired over a pending result")
    `FCPA_ASSERT(a_front_order, r_front <= r_open, "fresh pointer passed the open block end")
    `FCPA_ASSERT_NEVER(a_list_count, r_head_vld && (r_free_total == '0), "free list set with zero free count")
    `FCPA_ASSERT(a_free_count, (w_fire && r_op == OP_FREE && n_status == ST_OK) |=> (r_free_total == $past(r_free_total) + 1'b1), "free did not raise the free count")

endmodule
